[rtl/prg_pkg.sv]
// ----------------------------------------------------------------------------
// prg_pkg: shared types and constants of the primary ray generator
// Status codes, register indexes, reset values and fixed-point formats.
// ----------------------------------------------------------------------------
package prg_pkg;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_VIEWPORT = 2'd1,
      STATUS_ZERO_DIR = 2'd2
   } status_type;

   // register indexes on the csr port
   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_VIEWPORT = 3'd0;
   localparam csr_index_type CSR_PROJ_X   = 3'd1;
   localparam csr_index_type CSR_PROJ_Y   = 3'd2;
   localparam csr_index_type CSR_VIEW_0   = 3'd3;
   localparam csr_index_type CSR_VIEW_1   = 3'd4;
   localparam csr_index_type CSR_VIEW_2   = 3'd5;

   // reset values: unit viewport, identity matrices, zero origin
   localparam logic [63:0] RST_VIEWPORT = 64'h0001_0001_0000_0000;
   localparam logic [63:0] RST_PROJ_X   = 64'h0000_0000_0000_1000;
   localparam logic [63:0] RST_PROJ_Y   = 64'h0000_0000_1000_0000;
   localparam logic [63:0] RST_VIEW_0   = 64'h0000_0000_0000_1000;
   localparam logic [63:0] RST_VIEW_1   = 64'h0000_0000_1000_0000;
   localparam logic [63:0] RST_VIEW_2   = 64'h0000_1000_0000_0000;

   // fixed-point formats
   localparam int NDC_FRAC  = 16;   // fraction bits of ndc and eye values
   localparam int MAG_BITS  = 30;   // normalized magnitude width
   localparam int SUM_BITS  = 62;   // sum of three squared magnitudes
   localparam int ROOT_BITS = 31;   // floor square root of the sum
   localparam int DIR_FRAC  = 14;   // fraction bits of the unit direction
   localparam int DIR_QW    = 15;   // quotient bits of a direction component

endpackage

[rtl/primary_ray_generator.sv]
// ----------------------------------------------------------------------------
// primary_ray_generator: world-space primary ray for one pixel
// Pipeline: the ndc divider (one bit a stage), the square root (31 stages)
//   and the normalizing divider (15) are its longest parts.
// Throughput: one pixel accepted every cycle, busy stays low.
// Reset: synchronous; clears all stage valid bits and loads unit viewport,
//   identity matrices and zero origin into the registers.
// ----------------------------------------------------------------------------
module primary_ray_generator #(
   parameter int COORD_WIDTH    = 16,
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   // pixel request
   input  logic                     start,
   output logic                     busy,
   input  logic [15:0]              req_pixel_x,
   input  logic [15:0]              req_pixel_y,
   // ray result
   output logic                     rsp_valid,
   output logic signed [15:0]       rsp_origin_x,
   output logic signed [15:0]       rsp_origin_y,
   output logic signed [15:0]       rsp_origin_z,
   output logic signed [15:0]       rsp_dir_x,
   output logic signed [15:0]       rsp_dir_y,
   output logic signed [15:0]       rsp_dir_z,
   output prg_pkg::status_type      rsp_status,
   // register writes
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  prg_pkg::csr_index_type   csr_index,
   input  logic [63:0]              csr_data
);
   import prg_pkg::*;

   localparam int CW   = COORD_WIDTH;
   localparam int F    = COEF_FRAC_BITS;
   localparam int QXW  = CW + NDC_FRAC + 1;    // ndc quotient
   localparam int NXW  = QXW + 2;              // signed ndc
   localparam int PW   = 16 + NXW;             // eye products
   localparam int AW   = PW + 2;               // eye accumulator
   localparam int EW   = AW - F + 2;           // rounded eye value
   localparam int WPW  = 16 + EW;              // world products
   localparam int MW   = WPW + 2;              // world sum and magnitude
   localparam int NSH  = $clog2(MW);           // normalize steps
   localparam int LATENCY = QXW + NSH + ROOT_BITS + DIR_QW + 12;

   localparam logic signed [NXW-1:0] NDC_ONE = NXW'(1) <<< NDC_FRAC;

   // --------------------------------------------------------------- registers
   logic [63:0] vp_ff, proj_x_ff, proj_y_ff, view0_ff, view1_ff, view2_ff;
   logic [63:0] view_row [3];

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // take a word on the csr port
   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff     <= RST_VIEWPORT;
         proj_x_ff <= RST_PROJ_X;
         proj_y_ff <= RST_PROJ_Y;
         view0_ff  <= RST_VIEW_0;
         view1_ff  <= RST_VIEW_1;
         view2_ff  <= RST_VIEW_2;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_VIEWPORT: vp_ff     <= csr_data;
            CSR_PROJ_X:   proj_x_ff <= csr_data;
            CSR_PROJ_Y:   proj_y_ff <= csr_data;
            CSR_VIEW_0:   view0_ff  <= csr_data;
            CSR_VIEW_1:   view1_ff  <= csr_data;
            CSR_VIEW_2:   view2_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign view_row[0] = view0_ff;
   assign view_row[1] = view1_ff;
   assign view_row[2] = view2_ff;

   logic [CW-1:0] vp_left, vp_top, vp_w, vp_h;
   assign vp_left = vp_ff[0  +: CW];
   assign vp_top  = vp_ff[16 +: CW];
   assign vp_w    = vp_ff[32 +: CW];
   assign vp_h    = vp_ff[48 +: CW];

   // ----------------------------------------------- stage A: ndc numerators
   logic              a_valid_ff;
   logic [QXW-1:0]    a_numx_ff, a_numy_ff;
   logic              a_negx_ff, a_negy_ff, a_zero_ff;
   logic signed [CW:0] dx_in, dy_in;
   logic [CW-1:0]     magx_in, magy_in;

   always_comb begin
      dx_in   = $signed({1'b0, req_pixel_x[CW-1:0]}) - $signed({1'b0, vp_left});
      dy_in   = $signed({1'b0, req_pixel_y[CW-1:0]}) - $signed({1'b0, vp_top});
      magx_in = dx_in[CW] ? CW'(-dx_in) : CW'(dx_in);
      magy_in = dy_in[CW] ? CW'(-dy_in) : CW'(dy_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start && !busy;
      end
      a_numx_ff <= {magx_in, (NDC_FRAC + 1)'(0)} + QXW'(vp_w >> 1);
      a_numy_ff <= {magy_in, (NDC_FRAC + 1)'(0)} + QXW'(vp_h >> 1);
      a_negx_ff <= dx_in[CW];
      a_negy_ff <= dy_in[CW];
      a_zero_ff <= (vp_w == '0) || (vp_h == '0);
   end

   // ------------------------------------------------------ ndc dividers
   logic           dvx_valid;
   logic [QXW-1:0] dvx_quo, dvy_quo;
   logic [1:0]     dvx_tag;
   logic           dvy_tag;

   prg_div_pipe #(.DW(CW), .QW(QXW), .TW(2)) u_div_ndc_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid_ff),
      .in_rem    ('0),
      .in_low    (a_numx_ff),
      .in_den    (vp_w),
      .in_tag    ({a_negx_ff, a_zero_ff}),
      .out_valid (dvx_valid),
      .out_quo   (dvx_quo),
      .out_tag   (dvx_tag)
   );

   prg_div_pipe #(.DW(CW), .QW(QXW), .TW(1)) u_div_ndc_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid_ff),
      .in_rem    ('0),
      .in_low    (a_numy_ff),
      .in_den    (vp_h),
      .in_tag    (a_negy_ff),
      .out_valid (),
      .out_quo   (dvy_quo),
      .out_tag   (dvy_tag)
   );

   // ------------------------------------------------ stage B: signed ndc
   logic                  b_valid_ff;
   logic signed [NXW-1:0] b_nx_ff, b_ny_ff;
   logic [1:0]            b_st_ff;
   logic signed [NXW-1:0] qx_s, qy_s;

   always_comb begin
      qx_s = $signed({2'b00, dvx_quo});
      qy_s = $signed({2'b00, dvy_quo});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= dvx_valid;
      end
      b_nx_ff <= (dvx_tag[1] ? -qx_s : qx_s) - NDC_ONE;
      b_ny_ff <= NDC_ONE - (dvy_tag ? -qy_s : qy_s);
      b_st_ff <= dvx_tag[0] ? STATUS_VIEWPORT : STATUS_OK;
   end

   // ------------------------------------------- stage E1: eye products
   logic                 e1_valid_ff;
   logic signed [PW-1:0] e1_p_ff [2][2];
   logic signed [16:0]   e1_cd_ff [2];
   logic [1:0]           e1_st_ff;
   logic [63:0]          proj_row [2];

   assign proj_row[0] = proj_x_ff;
   assign proj_row[1] = proj_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
      end else begin
         e1_valid_ff <= b_valid_ff;
      end
      for (int r = 0; r < 2; r++) begin
         e1_p_ff[r][0] <= $signed(proj_row[r][15:0]) * b_nx_ff;
         e1_p_ff[r][1] <= $signed(proj_row[r][31:16]) * b_ny_ff;
         e1_cd_ff[r]   <= 17'($signed(proj_row[r][63:48])) -
                          17'($signed(proj_row[r][47:32]));
      end
      e1_st_ff <= b_st_ff;
   end

   // ------------------------------------------- stage E2: eye accumulate
   logic                 e2_valid_ff;
   logic signed [AW-1:0] e2_acc_ff [2];
   logic [1:0]           e2_st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e2_valid_ff <= 1'b0;
      end else begin
         e2_valid_ff <= e1_valid_ff;
      end
      for (int r = 0; r < 2; r++) begin
         e2_acc_ff[r] <= AW'(e1_p_ff[r][0]) + AW'(e1_p_ff[r][1]) +
                         (AW'(e1_cd_ff[r]) <<< NDC_FRAC);
      end
      e2_st_ff <= e1_st_ff;
   end

   // ----------------------------------------------- stage E3: eye rounding
   logic                 e3_valid_ff;
   logic signed [EW-1:0] e3_eye_ff [2];
   logic [1:0]           e3_st_ff;
   logic [AW-1:0]        acc_mag [2];
   logic [AW-1:0]        acc_rnd [2];

   // round half away from zero on the magnitude
   always_comb begin
      for (int r = 0; r < 2; r++) begin
         acc_mag[r] = e2_acc_ff[r][AW-1] ? AW'(-e2_acc_ff[r]) : AW'(e2_acc_ff[r]);
         acc_rnd[r] = (acc_mag[r] + (AW'(1) << (F - 1))) >> F;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e3_valid_ff <= 1'b0;
      end else begin
         e3_valid_ff <= e2_valid_ff;
      end
      for (int r = 0; r < 2; r++) begin
         e3_eye_ff[r] <= e2_acc_ff[r][AW-1] ? -$signed(EW'(acc_rnd[r]))
                                             : $signed(EW'(acc_rnd[r]));
      end
      e3_st_ff <= e2_st_ff;
   end

   // --------------------------------------------- stage W1: world products
   logic                  w1_valid_ff;
   logic signed [WPW-1:0] w1_p_ff [3][2];
   logic [1:0]            w1_st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         w1_valid_ff <= 1'b0;
      end else begin
         w1_valid_ff <= e3_valid_ff;
      end
      for (int r = 0; r < 3; r++) begin
         w1_p_ff[r][0] <= $signed(view_row[r][15:0]) * e3_eye_ff[0];
         w1_p_ff[r][1] <= $signed(view_row[r][31:16]) * e3_eye_ff[1];
      end
      w1_st_ff <= e3_st_ff;
   end

   // ------------------------------ stage W2: world sum, eye z fixed at -1
   logic                 w2_valid_ff;
   logic [MW-1:0]        w2_mag_ff [3];
   logic                 w2_neg_ff [3];
   logic [1:0]           w2_st_ff;
   logic signed [MW-1:0] wsum [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         wsum[r] = MW'(w1_p_ff[r][0]) + MW'(w1_p_ff[r][1]) -
                   (MW'($signed(view_row[r][47:32])) <<< NDC_FRAC);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w2_valid_ff <= 1'b0;
      end else begin
         w2_valid_ff <= w1_valid_ff;
      end
      for (int r = 0; r < 3; r++) begin
         w2_mag_ff[r] <= wsum[r][MW-1] ? MW'(-wsum[r]) : MW'(wsum[r]);
         w2_neg_ff[r] <= wsum[r][MW-1];
      end
      w2_st_ff <= w1_st_ff;
   end

   // ------------------------------------- stage W3: largest magnitude
   logic          w3_valid_ff;
   logic [MW-1:0] w3_mag_ff [3];
   logic [MW-1:0] w3_max_ff;
   logic          w3_neg_ff [3];
   logic [1:0]    w3_st_ff;
   logic [MW-1:0] max01, max_in;

   always_comb begin
      max01  = (w2_mag_ff[0] > w2_mag_ff[1]) ? w2_mag_ff[0] : w2_mag_ff[1];
      max_in = (w2_mag_ff[2] > max01) ? w2_mag_ff[2] : max01;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w3_valid_ff <= 1'b0;
      end else begin
         w3_valid_ff <= w2_valid_ff;
      end
      w3_mag_ff <= w2_mag_ff;
      w3_neg_ff <= w2_neg_ff;
      w3_max_ff <= max_in;
      w3_st_ff  <= (w2_st_ff == STATUS_OK && max_in == '0) ? STATUS_ZERO_DIR : w2_st_ff;
   end

   // --------------------------- normalize: left-align the largest magnitude
   logic          nm_valid_ff [NSH];
   logic [MW-1:0] nm_mag_ff   [NSH][3];
   logic [MW-1:0] nm_max_ff   [NSH];
   logic          nm_neg_ff   [NSH][3];
   logic [1:0]    nm_st_ff    [NSH];

   for (genvar j = 0; j < NSH; j++) begin : g_norm
      localparam int K = 1 << (NSH - 1 - j);
      logic          cur_valid;
      logic [MW-1:0] cur_mag [3];
      logic [MW-1:0] cur_max;
      logic          cur_neg [3];
      logic [1:0]    cur_st;
      logic          shift_in;

      if (j == 0) begin : g_first
         assign cur_valid = w3_valid_ff;
         assign cur_mag   = w3_mag_ff;
         assign cur_max   = w3_max_ff;
         assign cur_neg   = w3_neg_ff;
         assign cur_st    = w3_st_ff;
      end else begin : g_next
         assign cur_valid = nm_valid_ff[j-1];
         assign cur_mag   = nm_mag_ff[j-1];
         assign cur_max   = nm_max_ff[j-1];
         assign cur_neg   = nm_neg_ff[j-1];
         assign cur_st    = nm_st_ff[j-1];
      end

      assign shift_in = (cur_max[MW-1 -: K] == '0);

      always_ff @(posedge clock) begin
         if (reset) begin
            nm_valid_ff[j] <= 1'b0;
         end else begin
            nm_valid_ff[j] <= cur_valid;
         end
         for (int r = 0; r < 3; r++) begin
            nm_mag_ff[j][r] <= shift_in ? (cur_mag[r] << K) : cur_mag[r];
         end
         nm_max_ff[j] <= shift_in ? (cur_max << K) : cur_max;
         nm_neg_ff[j] <= cur_neg;
         nm_st_ff[j]  <= cur_st;
      end
   end

   // ---------------------------------- stage Q1: top bits and squares
   logic                  q1_valid_ff;
   logic [MAG_BITS-1:0]   q1_mag_ff [3];
   logic [2*MAG_BITS-1:0] q1_sq_ff  [3];
   logic                  q1_neg_ff [3];
   logic [1:0]            q1_st_ff;
   logic [MAG_BITS-1:0]   top_mag [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         top_mag[r] = nm_mag_ff[NSH-1][r][MW-1 -: MAG_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_valid_ff <= 1'b0;
      end else begin
         q1_valid_ff <= nm_valid_ff[NSH-1];
      end
      for (int r = 0; r < 3; r++) begin
         q1_mag_ff[r] <= top_mag[r];
         q1_sq_ff[r]  <= top_mag[r] * top_mag[r];
      end
      q1_neg_ff <= nm_neg_ff[NSH-1];
      q1_st_ff  <= nm_st_ff[NSH-1];
   end

   // ---------------------------------------- stage Q2: sum of squares
   logic                q2_valid_ff;
   logic [SUM_BITS-1:0] q2_sum_ff;
   logic [MAG_BITS-1:0] q2_mag_ff [3];
   logic                q2_neg_ff [3];
   logic [1:0]          q2_st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q2_valid_ff <= 1'b0;
      end else begin
         q2_valid_ff <= q1_valid_ff;
      end
      q2_sum_ff <= SUM_BITS'(q1_sq_ff[0]) + SUM_BITS'(q1_sq_ff[1]) +
                   SUM_BITS'(q1_sq_ff[2]);
      q2_mag_ff <= q1_mag_ff;
      q2_neg_ff <= q1_neg_ff;
      q2_st_ff  <= q1_st_ff;
   end

   // ------------------------- square root: one root bit per stage
   localparam int RW = ROOT_BITS + 2;   // partial remainder

   logic                 sr_valid_ff [ROOT_BITS];
   logic [RW-1:0]        sr_rem_ff   [ROOT_BITS];
   logic [ROOT_BITS-1:0] sr_root_ff  [ROOT_BITS];
   logic [SUM_BITS-1:0]  sr_x_ff     [ROOT_BITS];
   logic [MAG_BITS-1:0]  sr_mag_ff   [ROOT_BITS][3];
   logic                 sr_neg_ff   [ROOT_BITS][3];
   logic [1:0]           sr_st_ff    [ROOT_BITS];

   for (genvar i = 0; i < ROOT_BITS; i++) begin : g_sqrt
      logic                 cur_valid;
      logic [RW-1:0]        cur_rem;
      logic [ROOT_BITS-1:0] cur_root;
      logic [SUM_BITS-1:0]  cur_x;
      logic [MAG_BITS-1:0]  cur_mag [3];
      logic                 cur_neg [3];
      logic [1:0]           cur_st;
      logic [RW+1:0]        part;
      logic [RW+1:0]        trial;
      logic                 ge;
      logic [RW-1:0]        rem_in;
      logic [ROOT_BITS-1:0] root_in;

      if (i == 0) begin : g_first
         assign cur_valid = q2_valid_ff;
         assign cur_rem   = '0;
         assign cur_root  = '0;
         assign cur_x     = q2_sum_ff;
         assign cur_mag   = q2_mag_ff;
         assign cur_neg   = q2_neg_ff;
         assign cur_st    = q2_st_ff;
      end else begin : g_next
         assign cur_valid = sr_valid_ff[i-1];
         assign cur_rem   = sr_rem_ff[i-1];
         assign cur_root  = sr_root_ff[i-1];
         assign cur_x     = sr_x_ff[i-1];
         assign cur_mag   = sr_mag_ff[i-1];
         assign cur_neg   = sr_neg_ff[i-1];
         assign cur_st    = sr_st_ff[i-1];
      end

      // bring down two bits, try root*4+1
      always_comb begin
         part    = {cur_rem, cur_x[SUM_BITS-1 -: 2]};
         trial   = (RW + 2)'({cur_root, 2'b01});
         ge      = (part >= trial);
         rem_in  = ge ? RW'(part - trial) : RW'(part);
         root_in = {cur_root[ROOT_BITS-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sr_valid_ff[i] <= 1'b0;
         end else begin
            sr_valid_ff[i] <= cur_valid;
         end
         sr_rem_ff[i]  <= rem_in;
         sr_root_ff[i] <= root_in;
         sr_x_ff[i]    <= cur_x << 2;
         sr_mag_ff[i]  <= cur_mag;
         sr_neg_ff[i]  <= cur_neg;
         sr_st_ff[i]   <= cur_st;
      end
   end

   // ------------------------------- stage F: normalizing dividends
   localparam int NNW = MAG_BITS + DIR_FRAC + 1;

   logic                 f_valid_ff;
   logic [NNW-1:0]       f_num_ff [3];
   logic [ROOT_BITS-1:0] f_len_ff;
   logic                 f_neg_ff [3];
   logic [1:0]           f_st_ff;
   logic [ROOT_BITS-1:0] len;

   assign len = sr_root_ff[ROOT_BITS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= sr_valid_ff[ROOT_BITS-1];
      end
      for (int r = 0; r < 3; r++) begin
         f_num_ff[r] <= NNW'({sr_mag_ff[ROOT_BITS-1][r], DIR_FRAC'(0)}) +
                        NNW'(len >> 1);
      end
      f_len_ff <= len;
      f_neg_ff <= sr_neg_ff[ROOT_BITS-1];
      f_st_ff  <= sr_st_ff[ROOT_BITS-1];
   end

   // ------------------------------------------ direction dividers
   logic              nd_valid;
   logic [DIR_QW-1:0] nd_quo [3];
   logic [2:0]        nd_tag_x;
   logic              nd_tag_y, nd_tag_z;

   prg_div_pipe #(.DW(ROOT_BITS), .QW(DIR_QW), .TW(3)) u_div_dir_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid_ff),
      .in_rem    (ROOT_BITS'(f_num_ff[0][NNW-1:DIR_QW])),
      .in_low    (f_num_ff[0][DIR_QW-1:0]),
      .in_den    (f_len_ff),
      .in_tag    ({f_st_ff, f_neg_ff[0]}),
      .out_valid (nd_valid),
      .out_quo   (nd_quo[0]),
      .out_tag   (nd_tag_x)
   );

   prg_div_pipe #(.DW(ROOT_BITS), .QW(DIR_QW), .TW(1)) u_div_dir_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid_ff),
      .in_rem    (ROOT_BITS'(f_num_ff[1][NNW-1:DIR_QW])),
      .in_low    (f_num_ff[1][DIR_QW-1:0]),
      .in_den    (f_len_ff),
      .in_tag    (f_neg_ff[1]),
      .out_valid (),
      .out_quo   (nd_quo[1]),
      .out_tag   (nd_tag_y)
   );

   prg_div_pipe #(.DW(ROOT_BITS), .QW(DIR_QW), .TW(1)) u_div_dir_z (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid_ff),
      .in_rem    (ROOT_BITS'(f_num_ff[2][NNW-1:DIR_QW])),
      .in_low    (f_num_ff[2][DIR_QW-1:0]),
      .in_den    (f_len_ff),
      .in_tag    (f_neg_ff[2]),
      .out_valid (),
      .out_quo   (nd_quo[2]),
      .out_tag   (nd_tag_z)
   );

   // ------------------------------------------------ output register
   logic              out_valid_ff;
   logic signed [15:0] out_dir_ff [3];
   logic signed [15:0] out_org_ff [3];
   status_type        out_st_ff;
   status_type        st_in;
   logic              nd_neg [3];

   assign st_in     = status_type'(nd_tag_x[2:1]);
   assign nd_neg[0] = nd_tag_x[0];
   assign nd_neg[1] = nd_tag_y;
   assign nd_neg[2] = nd_tag_z;

   // drop the direction on any error, reapply signs
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= nd_valid;
      end
      for (int r = 0; r < 3; r++) begin
         if (st_in != STATUS_OK) begin
            out_dir_ff[r] <= '0;
         end else begin
            out_dir_ff[r] <= nd_neg[r] ? -$signed(16'(nd_quo[r]))
                                       : $signed(16'(nd_quo[r]));
         end
         out_org_ff[r] <= $signed(view_row[r][63:48]);
      end
      out_st_ff <= st_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_dir_x    = out_dir_ff[0];
   assign rsp_dir_y    = out_dir_ff[1];
   assign rsp_dir_z    = out_dir_ff[2];
   assign rsp_origin_x = out_org_ff[0];
   assign rsp_origin_y = out_org_ff[1];
   assign rsp_origin_z = out_org_ff[2];
   assign rsp_status   = out_st_ff;

   // ------------------------------------------------------- assertions
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("ray result missing after pipeline latency");

   a_error_zero_dir: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |->
      (rsp_dir_x == 16'sd0 && rsp_dir_y == 16'sd0 && rsp_dir_z == 16'sd0))
      else $error("direction not cleared on error status");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_OK) |->
      (rsp_dir_x <= 16'sd16384 && rsp_dir_x >= -16'sd16384 &&
       rsp_dir_y <= 16'sd16384 && rsp_dir_y >= -16'sd16384 &&
       rsp_dir_z <= 16'sd16384 && rsp_dir_z >= -16'sd16384))
      else $error("direction component beyond unit length");

endmodule

[rtl/prg_div_pipe.sv]
// ----------------------------------------------------------------------------
// prg_div_pipe: pipelined restoring divider
// One quotient bit per stage. The caller splits the dividend into a high
// part (already below the divisor) and QW low bits; a tag rides along.
// ----------------------------------------------------------------------------
module prg_div_pipe #(
   parameter int DW = 16,
   parameter int QW = 33,
   parameter int TW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [DW-1:0] in_rem,
   input  logic [QW-1:0] in_low,
   input  logic [DW-1:0] in_den,
   input  logic [TW-1:0] in_tag,
   output logic          out_valid,
   output logic [QW-1:0] out_quo,
   output logic [TW-1:0] out_tag
);

   logic          valid_ff [QW];
   logic [DW-1:0] rem_ff   [QW];
   logic [QW-1:0] nq_ff    [QW];
   logic [DW-1:0] den_ff   [QW];
   logic [TW-1:0] tag_ff   [QW];

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic          cur_valid;
      logic [DW-1:0] cur_rem;
      logic [QW-1:0] cur_nq;
      logic [DW-1:0] cur_den;
      logic [TW-1:0] cur_tag;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] nq_in;

      // pick the stage source
      if (i == 0) begin : g_first
         assign cur_valid = in_valid;
         assign cur_rem   = in_rem;
         assign cur_nq    = in_low;
         assign cur_den   = in_den;
         assign cur_tag   = in_tag;
      end else begin : g_next
         assign cur_valid = valid_ff[i-1];
         assign cur_rem   = rem_ff[i-1];
         assign cur_nq    = nq_ff[i-1];
         assign cur_den   = den_ff[i-1];
         assign cur_tag   = tag_ff[i-1];
      end

      // shift in one dividend bit, subtract when it fits
      always_comb begin
         trial  = {cur_rem, cur_nq[QW-1]};
         diff   = trial - {1'b0, cur_den};
         ge     = (trial >= {1'b0, cur_den});
         rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
         nq_in  = {cur_nq[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= cur_valid;
         end
         rem_ff[i] <= rem_in;
         nq_ff[i]  <= nq_in;
         den_ff[i] <= cur_den;
         tag_ff[i] <= cur_tag;
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quo   = nq_ff[QW-1];
   assign out_tag   = tag_ff[QW-1];

endmodule

[tb/sv/prg_ray_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prg_ray_checker: ray prediction and comparison for primary_ray_generator
// Watches register writes, accepted pixels and result strobes, computes the
// expected ray for each pixel and compares each result word field by field.
// ----------------------------------------------------------------------------
module prg_ray_checker
   import prg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic [15:0]          req_pixel_x,
   input  logic [15:0]          req_pixel_y,
   input  logic                 rsp_valid,
   input  logic signed [15:0]   rsp_origin_x,
   input  logic signed [15:0]   rsp_origin_y,
   input  logic signed [15:0]   rsp_origin_z,
   input  logic signed [15:0]   rsp_dir_x,
   input  logic signed [15:0]   rsp_dir_y,
   input  logic signed [15:0]   rsp_dir_z,
   input  status_type           rsp_status,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  csr_index_type        csr_index,
   input  logic [63:0]          csr_data,
   output int                   fail_count,
   output int                   rays_pending
);

   typedef struct packed {
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
      logic signed [15:0] origin_z;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      status_type         status;
   } ray_type;

   logic [63:0] viewport_reg, proj_x_reg, proj_y_reg;
   logic [63:0] view_reg [3];
   ray_type     ray_queue [$];

   function automatic longint coef(logic [63:0] r, int k);
      return longint'($signed(r[16*k +: 16]));
   endfunction

   function automatic logic [63:0] mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   // nearest, ties away from zero
   function automatic longint div_nearest(longint num, logic [63:0] den);
      logic [63:0] q;
      q = (mag(num) + den / 2) / den;
      return num < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint shr_nearest(longint v, int s);
      logic [63:0] q;
      q = (mag(v) + (64'd1 << (s - 1))) >> s;
      return v < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [63:0] floor_sqrt(logic [63:0] x);
      logic [63:0] root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x = x - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic ray_type trace_ray(logic [15:0] px, logic [15:0] py);
      ray_type     r;
      longint      one, nx, ny, ex, ey, c;
      longint      eye [3];
      logic [63:0] m [3];
      logic        neg [3];
      logic [63:0] mx, sum, len, q;
      logic [63:0] w, h;
      one = 64'sd1 <<< NDC_FRAC;
      r = '0;
      r.origin_x = view_reg[0][63:48];
      r.origin_y = view_reg[1][63:48];
      r.origin_z = view_reg[2][63:48];
      w = 64'(viewport_reg[47:32]);
      h = 64'(viewport_reg[63:48]);
      if (w == 0 || h == 0) begin
         r.status = STATUS_VIEWPORT;
         return r;
      end
      nx = div_nearest((longint'(px) - longint'(viewport_reg[15:0])) * 2 * one, w) - one;
      ny = one - div_nearest((longint'(py) - longint'(viewport_reg[31:16])) * 2 * one, h);
      ex = shr_nearest(coef(proj_x_reg, 0) * nx + coef(proj_x_reg, 1) * ny
                       + (coef(proj_x_reg, 3) - coef(proj_x_reg, 2)) * one, 12);
      ey = shr_nearest(coef(proj_y_reg, 0) * nx + coef(proj_y_reg, 1) * ny
                       + (coef(proj_y_reg, 3) - coef(proj_y_reg, 2)) * one, 12);
      eye[0] = ex; eye[1] = ey; eye[2] = -one;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         c = coef(view_reg[i], 0) * eye[0] + coef(view_reg[i], 1) * eye[1]
           + coef(view_reg[i], 2) * eye[2];
         m[i] = mag(c);
         neg[i] = c < 0;
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
         r.status = STATUS_ZERO_DIR;
         return r;
      end
      // scale so the largest magnitude lands in [2^29, 2^30)
      while (mx >= (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) m[i] >>= 1;
         mx >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
         for (int i = 0; i < 3; i++) m[i] <<= 1;
         mx <<= 1;
      end
      sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      len = floor_sqrt(sum);
      q = ((m[0] << 14) + len / 2) / len; r.dir_x = neg[0] ? -q[15:0] : q[15:0];
      q = ((m[1] << 14) + len / 2) / len; r.dir_y = neg[1] ? -q[15:0] : q[15:0];
      q = ((m[2] << 14) + len / 2) / len; r.dir_z = neg[2] ? -q[15:0] : q[15:0];
      r.status = STATUS_OK;
      return r;
   endfunction

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name,
                  $signed(want), $signed(got));
      end
   endtask

   assign rays_pending = ray_queue.size();

   always @(posedge clock) begin
      ray_type want;
      if (reset) begin
         viewport_reg <= RST_VIEWPORT;
         proj_x_reg   <= RST_PROJ_X;
         proj_y_reg   <= RST_PROJ_Y;
         view_reg[0]  <= RST_VIEW_0;
         view_reg[1]  <= RST_VIEW_1;
         view_reg[2]  <= RST_VIEW_2;
         fail_count   = 0;
         ray_queue.delete();
      end else begin
         // compare the result word against the oldest prediction
         if (rsp_valid) begin
            if (ray_queue.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result word, actual dir %0d %0d %0d", $time,
                        rsp_dir_x, rsp_dir_y, rsp_dir_z);
            end else begin
               want = ray_queue.pop_front();
               check_field("origin_x", want.origin_x, rsp_origin_x);
               check_field("origin_y", want.origin_y, rsp_origin_y);
               check_field("origin_z", want.origin_z, rsp_origin_z);
               check_field("dir_x", want.dir_x, rsp_dir_x);
               check_field("dir_y", want.dir_y, rsp_dir_y);
               check_field("dir_z", want.dir_z, rsp_dir_z);
               check_field("status", 16'(want.status), 16'(rsp_status));
            end
         end
         if (start && !busy) ray_queue.push_back(trace_ray(req_pixel_x, req_pixel_y));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_VIEWPORT: viewport_reg <= csr_data;
               CSR_PROJ_X:   proj_x_reg   <= csr_data;
               CSR_PROJ_Y:   proj_y_reg   <= csr_data;
               CSR_VIEW_0:   view_reg[0]  <= csr_data;
               CSR_VIEW_1:   view_reg[1]  <= csr_data;
               CSR_VIEW_2:   view_reg[2]  <= csr_data;
               default: ;
            endcase
         end
      end
   end

endmodule

[tb/sv/tb_primary_ray_generator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_primary_ray_generator: pixel stimulus for the primary ray generator
// Loads camera settings between phases, sends directed and random pixels
// with varying idle gaps and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_primary_ray_generator;
   import prg_pkg::*;

   localparam int DRAIN_CYCLES = 120;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [15:0] req_pixel_x = 0, req_pixel_y = 0;
   logic rsp_valid;
   logic signed [15:0] rsp_origin_x, rsp_origin_y, rsp_origin_z;
   logic signed [15:0] rsp_dir_x, rsp_dir_y, rsp_dir_z;
   status_type rsp_status;
   logic csr_valid = 0;
   logic csr_ready;
   csr_index_type csr_index = CSR_VIEWPORT;
   logic [63:0] csr_data = 0;
   int fail_count, rays_pending;
   int idle_pct;

   always #4 clock = ~clock;

   primary_ray_generator dut (.*);

   prg_ray_checker ray_checker (.*);

   // write one register, hold until accepted
   task automatic write_reg(csr_index_type idx, logic [63:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // send one pixel, with a random idle gap first
   task automatic send_pixel(logic [15:0] px, logic [15:0] py);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(negedge clock);
      end
      start <= 1;
      req_pixel_x <= px;
      req_pixel_y <= py;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic drain;
      start <= 0;
      while (rays_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [15:0] coef_rand;
      case ($urandom_range(3))
         0: return 16'h1000;
         1: return 16'hF000;
         2: return 16'($urandom_range(16'h2000) - 16'h1000);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] row_rand;
      return {coef_rand(), coef_rand(), coef_rand(), coef_rand()};
   endfunction

   task automatic random_camera;
      logic [15:0] w, h;
      w = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 640));
      h = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 480));
      write_reg(CSR_VIEWPORT, {h, w, 16'($urandom_range(64)), 16'($urandom_range(64))});
      write_reg(CSR_PROJ_X, row_rand());
      write_reg(CSR_PROJ_Y, row_rand());
      write_reg(CSR_VIEW_0, row_rand());
      write_reg(CSR_VIEW_1, row_rand());
      write_reg(CSR_VIEW_2, row_rand());
   endtask

   initial begin
      #5ms;
      $display("primary_ray_generator test failed");
      $finish;
   end

   initial begin
      idle_pct = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: reset camera, field extremes
      send_pixel(0, 0);
      send_pixel(16'hFFFF, 16'hFFFF);
      send_pixel(1, 0);
      drain();
      write_reg(CSR_VIEWPORT, {16'd480, 16'd640, 16'd16, 16'd32});
      send_pixel(0, 0);
      send_pixel(32, 16);
      send_pixel(672, 496);
      send_pixel(351, 255);
      send_pixel(16'hFFFF, 0);
      send_pixel(16'h5555, 16'hAAAA);
      send_pixel(16'hAAAA, 16'h5555);
      drain();
      // zero viewport width, then height
      write_reg(CSR_VIEWPORT, {16'd480, 16'd0, 16'd0, 16'd0});
      send_pixel(5, 5);
      drain();
      write_reg(CSR_VIEWPORT, {16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF});
      send_pixel(5, 5);
      drain();
      // zero rotation gives a zero direction; extreme origins
      write_reg(CSR_VIEWPORT, {16'hFFFF, 16'hFFFF, 16'd0, 16'd0});
      write_reg(CSR_VIEW_0, 64'h7FFF_0000_0000_0000);
      write_reg(CSR_VIEW_1, 64'h8000_0000_0000_0000);
      write_reg(CSR_VIEW_2, 64'hFFFF_0000_0000_0000);
      send_pixel(100, 100);
      drain();
      write_reg(CSR_PROJ_X, 64'h8000_8000_8000_8000);
      write_reg(CSR_PROJ_Y, 64'h7FFF_7FFF_7FFF_7FFF);
      write_reg(CSR_VIEW_0, 64'h7FFF_7FFF_7FFF_7FFF);
      write_reg(CSR_VIEW_1, 64'h8000_8000_8000_8000);
      write_reg(CSR_VIEW_2, 64'h0010_8000_7FFF_1000);
      send_pixel(0, 16'hFFFF);
      send_pixel(16'hFFFF, 0);
      send_pixel(16'd32768, 16'd32768);
      drain();
      // random phases, new camera and idle rate each time
      for (int phase = 0; phase < 12; phase++) begin
         case (phase % 4)
            0: idle_pct = 0;
            1: idle_pct = 51;
            2: idle_pct = 32;
            default: idle_pct = 51;
         endcase
         random_camera();
         for (int n = 0; n < 100; n++) begin
            if ($urandom_range(9) == 0) send_pixel(16'($urandom), 16'($urandom));
            else send_pixel(16'($urandom_range(720)), 16'($urandom_range(560)));
         end
         drain();
      end
      if (fail_count == 0) begin
         $display("primary_ray_generator test passed");
      end else begin
         $display("primary_ray_generator test failed");
      end
      $finish;
   end

endmodule
